// ----- src/tpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the trade print aggregator: event codes,
// field widths, the result record and the output queue geometry.
// ----------------------------------------------------------------------------
package tpa_pkg;

  // Event kinds carried on in_cmd
  localparam logic [1:0] CMD_TRADE   = 2'd0;
  localparam logic [1:0] CMD_BOOK    = 2'd1;
  localparam logic [1:0] CMD_STATS   = 2'd2;
  localparam logic [1:0] CMD_END_REC = 2'd3;

  // Field widths
  localparam int SEC_W   = 20;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 31;
  localparam int TOT_W   = 32;
  localparam int CNT_W   = 16;
  localparam int SEQ_W   = 32;
  localparam int TIME_W  = 47;

  localparam logic [QTY_W-1:0] BULK_LIMIT_RESET = QTY_W'(1000000);
  localparam logic [TOT_W-1:0] TOT_MAX          = '1;
  localparam logic [CNT_W-1:0] CNT_MAX          = '1;

  // Output queue: room for two records per transaction plus slack
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One emitted trade record
  typedef struct packed {
    logic [SEC_W-1:0]          sec_id;
    logic signed [PRICE_W-1:0] price;
    logic [TOT_W-1:0]          total_quantity;
    logic [CNT_W-1:0]          trade_count;
    logic [SEQ_W-1:0]          seq_num;
    logic [TIME_W-1:0]         exch_time_ns;
    logic [TIME_W-1:0]         recv_time_ns;
    logic                      last;
  } rec_t;

endpackage

// ----- src/trade_print_aggregator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trade_print_aggregator
// Merges consecutive trades of one security at one price into one summed
// trade record; flushes on book updates, price or security changes and
// large trades.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one decoded feed event per transaction, taken at a
//   rising edge with in_valid high and in_stall low. Output channel (out_*):
//   one trade record per transaction; out_last marks the final record that
//   an input event caused. cfg_we/cfg_data write bulk_limit; write it only
//   while the block is idle.
//   Each event is processed as it is taken; its records are registered into
//   a four-entry output queue whose head drives out_*.
//   Throughput: one event per cycle while in_stall is low; an event that
//   emits two records fills two queue entries that leave in turn through
//   the single output port, so the queue drain sets the sustained rate.
//   in_stall rises when fewer than two queue entries are free, so a receiver
//   stall backs up into the input after the queue fills; no record is lost.
//   Reset: pending aggregate and sequence counter clear, the block enters
//   recovery mode (trades and stats ignored until an end-recovery event),
//   bulk_limit returns to 1000000 and the queue empties.
// ----------------------------------------------------------------------------
module trade_print_aggregator
  import tpa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [QTY_W-1:0]          cfg_data,
  // input events
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [SEC_W-1:0]          in_sec_id,
  input  logic signed [PRICE_W-1:0] in_price,
  input  logic [QTY_W-1:0]          in_quantity,
  input  logic [TIME_W-1:0]         in_exch_time_ns,
  input  logic [TIME_W-1:0]         in_recv_time_ns,
  // output records
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SEC_W-1:0]          out_sec_id,
  output logic signed [PRICE_W-1:0] out_price,
  output logic [TOT_W-1:0]          out_total_quantity,
  output logic [CNT_W-1:0]          out_trade_count,
  output logic [SEQ_W-1:0]          out_seq_num,
  output logic [TIME_W-1:0]         out_exch_time_ns,
  output logic [TIME_W-1:0]         out_recv_time_ns,
  output logic                      out_last
);

  // Configuration and aggregation state
  logic [QTY_W-1:0]          bulk_limit_r;
  logic [SEC_W-1:0]          pend_sec_r, pend_sec_nxt;
  logic signed [PRICE_W-1:0] pend_price_r, pend_price_nxt;
  logic [TOT_W-1:0]          pend_qty_r, pend_qty_nxt;
  logic [CNT_W-1:0]          pend_count_r, pend_count_nxt;
  logic [SEQ_W-1:0]          pend_seq_r, pend_seq_nxt;
  logic [TIME_W-1:0]         pend_exch_r, pend_exch_nxt;
  logic [TIME_W-1:0]         pend_recv_r, pend_recv_nxt;
  logic [SEQ_W-1:0]          seq_r, seq_nxt;
  logic                      rec_r, rec_nxt;

  // Output queue
  rec_t                      fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]        wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [FIFO_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]        count_r, count_nxt;

  // Datapath
  logic                      in_acc;
  logic                      out_acc;
  logic                      pend_live;
  logic                      key_diff;
  logic                      is_bulk;
  logic                      do_flush;
  logic [TOT_W-1:0]          base_qty;
  logic [CNT_W-1:0]          base_count;
  logic [TOT_W:0]            qty_sum;
  rec_t                      flush_rec;
  rec_t                      imm_rec;
  rec_t                      rec0, rec1;
  logic [1:0]                push_n;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Hold input while fewer than two queue entries are free
  assign in_stall  = count_r > FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;

  // Compare against the pending aggregate
  assign pend_live = pend_qty_r != '0;
  assign key_diff  = (in_sec_id != pend_sec_r) || (in_price != pend_price_r);
  assign is_bulk   = in_quantity >= bulk_limit_r;
  assign do_flush  = pend_live && (key_diff || is_bulk);

  // Merge base: cleared aggregate when it was flushed by this trade
  assign base_qty   = do_flush ? '0 : pend_qty_r;
  assign base_count = do_flush ? '0 : pend_count_r;
  assign qty_sum    = {1'b0, base_qty} + (TOT_W + 1)'(in_quantity);

  // Record for the pending aggregate
  always_comb begin
    flush_rec.sec_id         = pend_sec_r;
    flush_rec.price          = pend_price_r;
    flush_rec.total_quantity = pend_qty_r;
    flush_rec.trade_count    = pend_count_r;
    flush_rec.seq_num        = pend_seq_r;
    flush_rec.exch_time_ns   = pend_exch_r;
    flush_rec.recv_time_ns   = pend_recv_r;
    flush_rec.last           = 1'b1;
  end

  // Record for a trade that bypasses aggregation
  always_comb begin
    imm_rec.sec_id         = in_sec_id;
    imm_rec.price          = in_price;
    imm_rec.total_quantity = TOT_W'(in_quantity);
    imm_rec.trade_count    = CNT_W'(1);
    imm_rec.seq_num        = seq_r;
    imm_rec.exch_time_ns   = in_exch_time_ns;
    imm_rec.recv_time_ns   = in_recv_time_ns;
    imm_rec.last           = 1'b1;
  end

  // Process one event: update state and pick the records to queue
  always_comb begin
    pend_sec_nxt   = pend_sec_r;
    pend_price_nxt = pend_price_r;
    pend_qty_nxt   = pend_qty_r;
    pend_count_nxt = pend_count_r;
    pend_seq_nxt   = pend_seq_r;
    pend_exch_nxt  = pend_exch_r;
    pend_recv_nxt  = pend_recv_r;
    seq_nxt        = seq_r;
    rec_nxt        = rec_r;
    rec0           = flush_rec;
    rec1           = imm_rec;
    push_n         = 2'd0;
    if (in_acc) begin
      case (in_cmd)
        CMD_TRADE: begin
          if (!rec_r) begin
            seq_nxt = seq_r + SEQ_W'(1);
            if (do_flush) begin
              pend_sec_nxt   = '0;
              pend_price_nxt = '0;
              pend_qty_nxt   = '0;
              pend_count_nxt = '0;
              pend_seq_nxt   = '0;
            end
            if (is_bulk) begin
              if (do_flush) begin
                rec0.last = 1'b0;
                push_n    = 2'd2;
              end else begin
                rec0   = imm_rec;
                push_n = 2'd1;
              end
            end else begin
              push_n         = do_flush ? 2'd1 : 2'd0;
              pend_sec_nxt   = in_sec_id;
              pend_price_nxt = in_price;
              pend_qty_nxt   = qty_sum[TOT_W] ? TOT_MAX : qty_sum[TOT_W-1:0];
              pend_count_nxt = (base_count != CNT_MAX) ? base_count + CNT_W'(1)
                                                       : base_count;
              pend_seq_nxt   = seq_r;
              pend_exch_nxt  = in_exch_time_ns;
              pend_recv_nxt  = in_recv_time_ns;
            end
          end
        end
        CMD_BOOK: begin
          seq_nxt = seq_r + SEQ_W'(1);
          if (pend_live) begin
            push_n         = 2'd1;
            pend_sec_nxt   = '0;
            pend_price_nxt = '0;
            pend_qty_nxt   = '0;
            pend_count_nxt = '0;
            pend_seq_nxt   = '0;
          end
        end
        CMD_STATS: begin
          if (!rec_r) begin
            seq_nxt = seq_r + SEQ_W'(1);
          end
        end
        CMD_END_REC: begin
          rec_nxt = 1'b0;
        end
        default: begin
          rec_nxt = rec_r;
        end
      endcase
    end
  end

  // Advance queue pointers and occupancy
  assign wr_ptr_p1  = wr_ptr_r + FIFO_AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_n);
  assign rd_ptr_nxt = out_acc ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
  assign count_nxt  = count_r + FIFO_CW'(push_n) - FIFO_CW'(out_acc);

  // Control and aggregation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bulk_limit_r <= BULK_LIMIT_RESET;
      pend_sec_r   <= '0;
      pend_price_r <= '0;
      pend_qty_r   <= '0;
      pend_count_r <= '0;
      pend_seq_r   <= '0;
      pend_exch_r  <= '0;
      pend_recv_r  <= '0;
      seq_r        <= '0;
      rec_r        <= 1'b1;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_we) begin
        bulk_limit_r <= cfg_data;
      end
      pend_sec_r   <= pend_sec_nxt;
      pend_price_r <= pend_price_nxt;
      pend_qty_r   <= pend_qty_nxt;
      pend_count_r <= pend_count_nxt;
      pend_seq_r   <= pend_seq_nxt;
      pend_exch_r  <= pend_exch_nxt;
      pend_recv_r  <= pend_recv_nxt;
      seq_r        <= seq_nxt;
      rec_r        <= rec_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      count_r      <= count_nxt;
    end
  end

  // Write queued records
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= rec0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_p1] <= rec1;
    end
  end

  // Present the head of the queue
  assign out_sec_id         = fifo_r[rd_ptr_r].sec_id;
  assign out_price          = fifo_r[rd_ptr_r].price;
  assign out_total_quantity = fifo_r[rd_ptr_r].total_quantity;
  assign out_trade_count    = fifo_r[rd_ptr_r].trade_count;
  assign out_seq_num        = fifo_r[rd_ptr_r].seq_num;
  assign out_exch_time_ns   = fifo_r[rd_ptr_r].exch_time_ns;
  assign out_recv_time_ns   = fifo_r[rd_ptr_r].recv_time_ns;
  assign out_last           = fifo_r[rd_ptr_r].last;

  // Queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("output queue occupancy above depth");

  // Recovery mode is only entered at reset
  a_rec_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$rose(rec_r))
    else $error("recovery mode re-entered without reset");

  // A live trade takes exactly one sequence number
  a_trade_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_TRADE && !rec_r) |=> seq_r == $past(seq_r) + SEQ_W'(1))
    else $error("trade did not advance sequence counter");

  // A book update leaves nothing pending
  a_book_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_BOOK) |=> pend_qty_r == '0)
    else $error("aggregate still pending after book update");

endmodule
